>>> hdl/scfd_pkg.sv
// Shared types, codes and helpers for the additive-checksum frame deframer.
package scfd_pkg;

  localparam int MARKER_BYTES_DEF = 4;

  localparam int CFG_ADDR_W = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_START_PATTERN = 3'd0;
  localparam logic [2:0] REG_START_LENGTH  = 3'd1;
  localparam logic [2:0] REG_END_PATTERN   = 3'd2;
  localparam logic [2:0] REG_END_LENGTH    = 3'd3;
  localparam logic [2:0] REG_RS485_MODE    = 3'd4;
  localparam logic [2:0] REG_BROADCAST     = 3'd5;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CHECKSUM = 2'd1,
    ERR_END      = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TARGET  = 3'd1,
    PH_SOURCE  = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5,
    PH_END     = 3'd6
  } phase_t;

  typedef struct packed {
    logic [31:0] start_pattern;
    logic [2:0]  start_length;
    logic [31:0] end_pattern;
    logic [2:0]  end_length;
    logic        rs485_mode;
    logic [7:0]  broadcast_address;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_position;
    logic       frame_ok;
    err_t       error_code;
    logic [7:0] dest_addr;
    logic [7:0] src_addr;
    logic [7:0] payload_length;
  } result_t;

  // Marker byte k of a 32-bit pattern; bytes beyond the register read as zero
  function automatic logic [7:0] marker_byte(input logic [31:0] pat, input logic [2:0] k);
    logic [63:0] wide;
    wide = {32'd0, pat};
    return wide[{k, 3'b000} +: 8];
  endfunction

endpackage

>>> hdl/sum_checksum_frame_deframer.sv
// Top level of the byte-stream frame deframer with additive checksum.
//
// Usage
//   Received bytes enter on the s_axis channel, one byte a beat; tlast marks
//   the last byte of a receive buffer and aborts any unfinished frame.
//   Results leave on the m_axis channel: tuser 0 is a payload byte, tuser 1
//   is the frame verdict (ok flag, error code and the held headers).
//   The registers sit on the APB-style port; the user must write them only
//   while the block is idle, which the block itself does not enforce.
// Throughput and data path
//   One byte per clock while the receiver keeps m_axis_tready high. A byte
//   accepted on s_axis sits in the input register and is parsed from there
//   into the result register, from which its result shows on m_axis. The
//   parse is one compare and one 8-bit add per byte, done combinationally.
// Reset and stall
//   Synchronous reset empties both registers, returns the parser to the
//   hunt and loads the register reset values. When the receiver stalls the
//   result holds in its register, the input register still takes a byte if
//   it is empty, and s_axis_tready then drops until the result beat moves.
module sum_checksum_frame_deframer import scfd_pkg::*; #(
  parameter int MARKER_BYTES = MARKER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB-style configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Received bytes
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic                  s_axis_tlast,   // buffer_end
  // Results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] payload_byte, [15:8] payload_position, [16] frame_ok,
  // [18:17] error_code, [26:19] dest_addr, [34:27] src_addr,
  // [42:35] payload_length, [47:43] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser    // kind
);

  cfg_t     cfg;
  in_beat_t in_beat, held_beat;
  logic     held_valid;
  logic     advance;
  logic     can_load;
  logic     has_result;
  result_t  step_result, out_result;

  assign pready = 1'b1;

  scfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign in_beat.rx_byte    = s_axis_tdata;
  assign in_beat.buffer_end = s_axis_tlast;

  // Advance the held byte whenever the result register can take what it yields
  assign advance = held_valid && can_load;

  scfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_beat    (in_beat),
    .held_valid (held_valid),
    .held_beat  (held_beat),
    .advance    (advance)
  );

  scfd_parser #(
    .MARKER_BYTES (MARKER_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .advance    (advance),
    .beat       (held_beat),
    .has_result (has_result),
    .result     (step_result)
  );

  scfd_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && has_result),
    .load_result (step_result),
    .can_load    (can_load),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_result  (out_result)
  );

  assign m_axis_tuser = out_result.kind;
  assign m_axis_tdata = {5'd0,
                         out_result.payload_length,
                         out_result.src_addr,
                         out_result.dest_addr,
                         out_result.error_code,
                         out_result.frame_ok,
                         out_result.payload_position,
                         out_result.payload_byte};

  // An empty result register must never hold back the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with result register empty");

  // A passing verdict carries no error code
  a_ok_no_error: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_VERDICT && m_axis_tdata[16])
      |-> (m_axis_tdata[18:17] == ERR_NONE))
    else $error("passing verdict with an error code");

  // A payload beat carries neither the ok flag nor an error code
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD) |-> (m_axis_tdata[18:16] == 3'd0))
    else $error("payload beat with verdict fields set");

  // A held byte with room downstream is always consumed in that cycle
  a_held_moves: assert property (@(posedge clk) disable iff (rst)
    (held_valid && can_load && !s_axis_tvalid) |=> !held_valid)
    else $error("held byte not consumed");

endmodule

>>> hdl/scfd_cfg_regs.sv
// Configuration register bank behind the APB-style port.
module scfd_cfg_regs import scfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output cfg_t                  cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pattern     <= 32'd0;
      cfg.start_length      <= 3'd1;
      cfg.end_pattern       <= 32'd0;
      cfg.end_length        <= 3'd1;
      cfg.rs485_mode        <= 1'b0;
      cfg.broadcast_address <= 8'd0;
    end else if (wr) begin
      unique case (idx)
        REG_START_PATTERN: cfg.start_pattern     <= pwdata;
        REG_START_LENGTH:  cfg.start_length      <= pwdata[2:0];
        REG_END_PATTERN:   cfg.end_pattern       <= pwdata;
        REG_END_LENGTH:    cfg.end_length        <= pwdata[2:0];
        REG_RS485_MODE:    cfg.rs485_mode        <= pwdata[0];
        REG_BROADCAST:     cfg.broadcast_address <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_PATTERN: prdata = cfg.start_pattern;
      REG_START_LENGTH:  prdata = {29'd0, cfg.start_length};
      REG_END_PATTERN:   prdata = cfg.end_pattern;
      REG_END_LENGTH:    prdata = {29'd0, cfg.end_length};
      REG_RS485_MODE:    prdata = {31'd0, cfg.rs485_mode};
      REG_BROADCAST:     prdata = {24'd0, cfg.broadcast_address};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

>>> hdl/scfd_in_stage.sv
// Input register: holds one received beat until the parser takes it.
module scfd_in_stage import scfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  output logic     held_valid,
  output in_beat_t held_beat,
  input  logic     advance
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_beat <= in_beat;
    end
  end

endmodule

>>> hdl/scfd_parser.sv
// Frame parser: phase, marker match, running sum and held headers; one beat a cycle while advance is high.
module scfd_parser import scfd_pkg::*; #(
  parameter int MARKER_BYTES = MARKER_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     advance,
  input  in_beat_t beat,
  output logic     has_result,
  output result_t  result
);

  localparam int CW = $clog2(MARKER_BYTES + 1);
  localparam logic [3:0] MB = 4'(MARKER_BYTES);

  phase_t      phase, phase_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  tgt, tgt_next;
  logic [7:0]  src, src_next;
  logic [7:0]  len, len_next;
  logic [7:0]  pcnt, pcnt_next;

  logic [3:0]  slen, elen, cnt_inc;
  logic [7:0]  start_sum, sum_b;
  logic        is_verdict, is_payload, ok;
  err_t        err;

  always_comb begin
    if (cfg.start_length == 3'd0)           slen = 4'd1;
    else if ({1'b0, cfg.start_length} > MB) slen = MB;
    else                                    slen = {1'b0, cfg.start_length};
    if ({1'b0, cfg.end_length} > MB)        elen = MB;
    else                                    elen = {1'b0, cfg.end_length};
  end

  // Sum of the start marker bytes in use, seeds the checksum
  always_comb begin
    start_sum = 8'd0;
    for (int k = 0; k < MARKER_BYTES; k++) begin
      if (4'(k) < slen) start_sum = start_sum + marker_byte(cfg.start_pattern, 3'(k));
    end
  end

  assign cnt_inc = 4'(cnt) + 4'd1;
  assign sum_b   = sum + beat.rx_byte;

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    sum_next   = sum;
    tgt_next   = tgt;
    src_next   = src;
    len_next   = len;
    pcnt_next  = pcnt;
    is_payload = 1'b0;
    is_verdict = 1'b0;
    ok         = 1'b0;
    err        = ERR_NONE;

    unique case (phase)
      PH_HUNT: begin
        if (beat.rx_byte == marker_byte(cfg.start_pattern, 3'(cnt))) begin
          if (cnt_inc >= slen) begin
            sum_next   = start_sum;
            tgt_next   = cfg.rs485_mode ? 8'd0 : cfg.broadcast_address;
            src_next   = 8'd0;
            len_next   = 8'd0;
            pcnt_next  = 8'd0;
            cnt_next   = '0;
            phase_next = cfg.rs485_mode ? PH_TARGET : PH_SOURCE;
          end else begin
            cnt_next = CW'(cnt_inc);
          end
        end else begin
          cnt_next = '0;
        end
      end
      PH_TARGET: begin
        tgt_next   = beat.rx_byte;
        sum_next   = sum_b;
        phase_next = PH_SOURCE;
      end
      PH_SOURCE: begin
        src_next   = beat.rx_byte;
        sum_next   = sum_b;
        phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        len_next   = beat.rx_byte;
        sum_next   = sum_b;
        pcnt_next  = 8'd0;
        phase_next = (beat.rx_byte != 8'd0) ? PH_PAYLOAD : PH_CHECK;
      end
      PH_PAYLOAD: begin
        sum_next   = sum_b;
        is_payload = 1'b1;
        pcnt_next  = pcnt + 8'd1;
        if ({1'b0, pcnt} + 9'd1 >= {1'b0, len}) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        sum_next = sum_b;
        if (sum_b != 8'd0) begin
          is_verdict = 1'b1;
          err        = ERR_CHECKSUM;
        end else if (elen == 4'd0) begin
          is_verdict = 1'b1;
          ok         = 1'b1;
        end else begin
          cnt_next   = '0;
          phase_next = PH_END;
        end
      end
      PH_END: begin
        if (beat.rx_byte == marker_byte(cfg.end_pattern, 3'(cnt))) begin
          if (cnt_inc >= elen) begin
            is_verdict = 1'b1;
            ok         = 1'b1;
          end else begin
            cnt_next = CW'(cnt_inc);
          end
        end else begin
          is_verdict = 1'b1;
          err        = ERR_END;
        end
      end
      default: begin
        phase_next = PH_HUNT;
        cnt_next   = '0;
        sum_next   = 8'd0;
      end
    endcase

    if (is_verdict) begin
      phase_next = PH_HUNT;
      cnt_next   = '0;
      sum_next   = 8'd0;
    end

    // Buffer end: abort an unfinished frame, drop a partial start match
    if (beat.buffer_end) begin
      if (phase_next != PH_HUNT) begin
        is_verdict = 1'b1;
        ok         = 1'b0;
        err        = ERR_TRUNC;
        phase_next = PH_HUNT;
        sum_next   = 8'd0;
      end
      cnt_next = '0;
    end
  end

  // Result beat for the current byte; a verdict replaces any payload beat
  always_comb begin
    has_result              = is_verdict || is_payload;
    result.kind             = is_verdict ? KIND_VERDICT : KIND_PAYLOAD;
    result.payload_byte     = is_verdict ? 8'd0 : beat.rx_byte;
    result.payload_position = is_verdict ? 8'd0 : pcnt;
    result.frame_ok         = ok;
    result.error_code       = err;
    result.dest_addr        = tgt_next;
    result.src_addr         = src_next;
    result.payload_length   = len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      cnt   <= '0;
      sum   <= 8'd0;
      tgt   <= 8'd0;
      src   <= 8'd0;
      len   <= 8'd0;
      pcnt  <= 8'd0;
    end else if (advance) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      sum   <= sum_next;
      tgt   <= tgt_next;
      src   <= src_next;
      len   <= len_next;
      pcnt  <= pcnt_next;
    end
  end

endmodule

>>> hdl/scfd_out_stage.sv
// Result register: holds one result beat until the receiver takes it.
module scfd_out_stage import scfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_result,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_result <= load_result;
    end
  end

endmodule
